FILE: hdl/s2s_pkg.sv
// ----------------------------------------------------------------------------
// Strided 2D slice package
// Register widths, register indexes and the classification record passed
// from the front end to the top level.
// ----------------------------------------------------------------------------
package s2s_pkg;

   localparam int DIM_CFG_W   = 13;
   localparam int START_W     = 12;
   localparam int END_W       = 14;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TENSOR_WIDTH  = 3'd0,
      CSR_TENSOR_HEIGHT = 3'd1,
      CSR_ROW_START     = 3'd2,
      CSR_ROW_END       = 3'd3,
      CSR_ROW_STEP      = 3'd4,
      CSR_COL_START     = 3'd5,
      CSR_COL_END       = 3'd6,
      CSR_COL_STEP      = 3'd7
   } s2s_csr_type;

   typedef struct packed {
      logic sel;
      logic last;
   } s2s_class_type;

endpackage

FILE: hdl/s2s_front.sv
// ----------------------------------------------------------------------------
// Strided 2D slice front end
// Holds the configuration, the position and phase counters, and classifies
// each incoming element as selected or not and as the last of the frame.
// ----------------------------------------------------------------------------
module s2s_front
   import s2s_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   item_accept,
   output s2s_class_type          cls,
   output logic                   cfg_busy
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int DIM_W = POS_W + 1;
   localparam int SW    = (POS_W + 3 > 15) ? POS_W + 3 : 15;
   localparam logic [SW-1:0] MAX_DIM_S = SW'(MAX_DIM);

   // Raw register file.
   logic [DIM_CFG_W-1:0]    width_ff, height_ff, row_step_ff, col_step_ff;
   logic [START_W-1:0]      row_start_ff, col_start_ff;
   logic signed [END_W-1:0] row_end_ff, col_end_ff;

   // Derived limits, refreshed every cycle from the raw registers.
   logic [DIM_W-1:0]     w_ff, h_ff, rs_ff, cs_ff;
   logic signed [SW-1:0] re_ff, ce_ff;
   logic                 busy_ff;

   logic [POS_W-1:0] col_pos_ff, row_pos_ff, col_phase_ff, row_phase_ff;
   logic [POS_W-1:0] col_pos_in, row_pos_in, col_phase_in, row_phase_in;
   logic [POS_W-1:0] col_phase_nx, row_phase_nx;

   logic signed [SW-1:0] row_pos_s, col_pos_s, row_phase_s, col_phase_s;
   logic signed [SW-1:0] row_start_s, col_start_s, rs_s, cs_s, w_s, h_s;
   logic                 row_sel, col_sel, last_row, last_col, col_wrap, row_wrap;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
      logic [SW-1:0] ve;
      ve = SW'(v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (ve > MAX_DIM_S) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(v);
   endfunction

   // An end of zero or below counts from the far edge; the result never
   // exceeds the dimension.
   function automatic logic signed [SW-1:0] eff_end(input logic signed [END_W-1:0] raw,
                                                    input logic [DIM_W-1:0] dim);
      logic signed [SW-1:0] e;
      logic signed [SW-1:0] d;
      e = {{(SW-END_W){raw[END_W-1]}}, raw};
      d = $signed({{(SW-DIM_W){1'b0}}, dim});
      if (e <= 0) begin
         e = e + d;
      end
      if (e > d) begin
         e = d;
      end
      return e;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_CFG_W'(1);
         height_ff    <= DIM_CFG_W'(1);
         row_start_ff <= '0;
         row_end_ff   <= '0;
         row_step_ff  <= DIM_CFG_W'(1);
         col_start_ff <= '0;
         col_end_ff   <= '0;
         col_step_ff  <= DIM_CFG_W'(1);
      end else if (csr_write) begin
         unique case (s2s_csr_type'(csr_index))
            CSR_TENSOR_WIDTH:  width_ff     <= csr_data[DIM_CFG_W-1:0];
            CSR_TENSOR_HEIGHT: height_ff    <= csr_data[DIM_CFG_W-1:0];
            CSR_ROW_START:     row_start_ff <= csr_data[START_W-1:0];
            CSR_ROW_END:       row_end_ff   <= $signed(csr_data[END_W-1:0]);
            CSR_ROW_STEP:      row_step_ff  <= csr_data[DIM_CFG_W-1:0];
            CSR_COL_START:     col_start_ff <= csr_data[START_W-1:0];
            CSR_COL_END:       col_end_ff   <= $signed(csr_data[END_W-1:0]);
            CSR_COL_STEP:      col_step_ff  <= csr_data[DIM_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= clamp_dim(width_ff);
      h_ff  <= clamp_dim(height_ff);
      rs_ff <= clamp_dim(row_step_ff);
      cs_ff <= clamp_dim(col_step_ff);
      re_ff <= eff_end(row_end_ff, clamp_dim(height_ff));
      ce_ff <= eff_end(col_end_ff, clamp_dim(width_ff));
   end

   // The derived limits are registered from the raw registers, so input is held
   // off after each register write, while they settle, and after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= csr_write;
      end
   end

   assign cfg_busy = busy_ff;

   assign row_pos_s   = $signed({{(SW-POS_W){1'b0}}, row_pos_ff});
   assign col_pos_s   = $signed({{(SW-POS_W){1'b0}}, col_pos_ff});
   assign row_phase_s = $signed({{(SW-POS_W){1'b0}}, row_phase_ff});
   assign col_phase_s = $signed({{(SW-POS_W){1'b0}}, col_phase_ff});
   assign row_start_s = $signed({{(SW-START_W){1'b0}}, row_start_ff});
   assign col_start_s = $signed({{(SW-START_W){1'b0}}, col_start_ff});
   assign rs_s        = $signed({{(SW-DIM_W){1'b0}}, rs_ff});
   assign cs_s        = $signed({{(SW-DIM_W){1'b0}}, cs_ff});
   assign w_s         = $signed({{(SW-DIM_W){1'b0}}, w_ff});
   assign h_s         = $signed({{(SW-DIM_W){1'b0}}, h_ff});

   assign row_sel  = (row_pos_s >= row_start_s) && (row_pos_s < re_ff) && (row_phase_ff == '0);
   assign col_sel  = (col_pos_s >= col_start_s) && (col_pos_s < ce_ff) && (col_phase_ff == '0);
   assign last_row = (row_pos_s + rs_s) >= re_ff;
   assign last_col = (col_pos_s + cs_s) >= ce_ff;

   assign cls.sel  = row_sel & col_sel;
   assign cls.last = last_row & last_col;

   assign col_wrap = (col_pos_s + SW'(1)) >= w_s;
   assign row_wrap = (row_pos_s + SW'(1)) >= h_s;

   // The phase stays at zero until the start position is reached.
   always_comb begin
      if (col_pos_s < col_start_s) begin
         col_phase_nx = '0;
      end else if ((col_phase_s + SW'(1)) >= cs_s) begin
         col_phase_nx = '0;
      end else begin
         col_phase_nx = col_phase_ff + POS_W'(1);
      end
      if (row_pos_s < row_start_s) begin
         row_phase_nx = '0;
      end else if ((row_phase_s + SW'(1)) >= rs_s) begin
         row_phase_nx = '0;
      end else begin
         row_phase_nx = row_phase_ff + POS_W'(1);
      end
   end

   always_comb begin
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      if (item_accept) begin
         if (col_wrap) begin
            col_pos_in   = '0;
            col_phase_in = '0;
            if (row_wrap) begin
               row_pos_in   = '0;
               row_phase_in = '0;
            end else begin
               row_phase_in = row_phase_nx;
               row_pos_in   = row_pos_ff + POS_W'(1);
            end
         end else begin
            col_phase_in = col_phase_nx;
            col_pos_in   = col_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
      end else begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
      end
   end

endmodule

FILE: hdl/s2s_fifo.sv
// ----------------------------------------------------------------------------
// Strided 2D slice queue
// Small register queue between the front end and the output stage.
// DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module s2s_fifo #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

FILE: hdl/s2s_back.sv
// ----------------------------------------------------------------------------
// Strided 2D slice output stage
// Drains the queue into the result register and holds it while stalled.
// ----------------------------------------------------------------------------
module s2s_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  logic [DATA_WIDTH:0]   q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_out_data,
   output logic                  rsp_out_last
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] data_ff;
   logic                  last_ff;

   // A new transaction loads when the register is empty or being taken.
   assign q_pop    = !q_empty && (!valid_ff || !rsp_stall);
   assign valid_in = q_pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_data[DATA_WIDTH-1:0];
         last_ff <= q_data[DATA_WIDTH];
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_data = data_ff;
   assign rsp_out_last = last_ff;

endmodule

FILE: hdl/strided_2d_slice.sv
// ----------------------------------------------------------------------------
// Strided 2D slice
// Selects a strided rectangular window from a tensor streamed in raster order.
// ----------------------------------------------------------------------------
//   channel   ports                                   direction
//   request   req_valid, req_stall, req_elem_data     in
//   response  rsp_valid, rsp_stall, rsp_out_data/last out
//   control   csr_write, csr_index, csr_data          in
//
// One element is accepted per cycle while req_stall is low; a selected element
// is written to the queue at acceptance and moves on to the response register
// once that register is empty or being taken. Input is held off after reset and
// after each register write, while the derived window limits are recomputed.
// A response stall fills the two-entry queue and then stalls the request side.
// ----------------------------------------------------------------------------
module strided_2d_slice
   import s2s_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_DIM    = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DATA_WIDTH-1:0]  req_elem_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DATA_WIDTH-1:0]  rsp_out_data,
   output logic                   rsp_out_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   s2s_class_type         cls;
   logic                  cfg_busy;
   logic                  item_accept;
   logic                  q_push, q_pop, q_full, q_empty;
   logic [DATA_WIDTH:0]   q_wdata, q_rdata;

   assign req_stall   = q_full | cfg_busy;
   assign item_accept = req_valid & ~req_stall;
   assign q_push      = item_accept & cls.sel;
   assign q_wdata     = {cls.last, req_elem_data};

   s2s_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .item_accept (item_accept),
      .cls         (cls),
      .cfg_busy    (cfg_busy)
   );

   s2s_fifo #(
      .WIDTH (DATA_WIDTH + 1),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   s2s_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_data (rsp_out_data),
      .rsp_out_last (rsp_out_last)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue read while empty");

   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !(req_valid && !req_stall))
      else $error("transaction accepted before window limits settled");
`endif

endmodule
